/* sv/bdre_pkg.sv */
// Shared constants, types and state codes of the battery drain runtime estimator.
package bdre_pkg;

	localparam int SLOTS      = 8;
	localparam int WINDOW     = 4;
	localparam int TIME_BITS  = 40;

	localparam int SLOT_W     = 3;
	localparam int IDX_W      = $clog2(WINDOW);
	localparam int CNT_W      = $clog2(WINDOW + 1);
	localparam int ADDR_W     = $clog2(SLOTS * WINDOW);
	localparam int DEPTH      = SLOTS * WINDOW;

	localparam int PCT_W      = 7;
	localparam int RAW_W      = 8;
	localparam int CHG_W      = 2;
	localparam int DAYS_W     = 12;
	localparam int RATE_W     = 17;
	localparam int MINS_W     = 13;
	localparam int DIV_NUM_W  = 32;
	localparam int CNT_DIV_W  = $clog2(DIV_NUM_W + 1);

	localparam int IN_W       = 96;
	localparam int OUT_W      = 40;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam int DAY_S          = 86400;
	localparam int MIN_SPAN_S     = 20 * 60;
	localparam int MAX_MINUTES    = 72 * 60;
	localparam int FULL_LEVEL     = 100;
	localparam int RATE_SCALE     = 3600 * 256;
	localparam int MIN_PER_DROP   = 60;
	localparam int REM_SPAN_LIMIT = (MAX_MINUTES + 1) * 60 * FULL_LEVEL;
	localparam int REM_SPAN_W     = $clog2(REM_SPAN_LIMIT);

	localparam logic [CHG_W-1:0] CHG_DISCHARGING = 2'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOGGING   = 1'b0,
		REG_RETENTION = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] stamp;
		logic [PCT_W-1:0]     pct;
		logic [CHG_W-1:0]     chg;
	} edge_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_LDRAIN,
		ST_INS,
		ST_WB,
		ST_WALK,
		ST_CALC,
		ST_RSTART,
		ST_RWAIT,
		ST_PREPM,
		ST_MSTART,
		ST_MWAIT,
		ST_DONE
	} bdre_state_t;

	typedef struct packed {
		logic s_ready;
		logic rd_en;
		logic wr_en;
		logic div_start;
	} bdre_ctl_t;

endpackage

/* sv/bdre_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module bdre_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bdre_pkg::DIV_NUM_W-1:0]    num,
	input  logic [bdre_pkg::TIME_BITS-1:0]    den,
	output logic                              done,
	output logic [bdre_pkg::DIV_NUM_W-1:0]    quo
);
	import bdre_pkg::*;

	logic                     busy_q;
	logic                     done_q;
	logic [CNT_DIV_W-1:0]     cnt_q;
	logic [TIME_BITS:0]       rem_q;
	logic [DIV_NUM_W-1:0]     quo_q;
	logic [TIME_BITS-1:0]     den_q;
	logic [TIME_BITS:0]       trial;
	logic                     fits;

	assign trial = {rem_q[TIME_BITS-1:0], quo_q[DIV_NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_DIV_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_DIV_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without a busy cycle");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("divider count ran out while busy");

endmodule

/* sv/battery_drain_runtime_estimator.sv */
// Top level: slot edge memory, read-modify-write sequencer and drain estimate.
// Usage:
//  - Slave stream s_*: one battery reading per beat. Master stream m_*: one
//    result beat per reading, in order.
//  - Config channel cfg_*: index 0 logging_enabled, index 1 retention_days.
//    cfg_ready is always high; write only while no reading is in flight.
//  - Each reading reads its slot's window from the edge memory (one entry per
//    cycle, registered read), inserts the new edge in registers, writes the
//    window back if the edge was inserted, walks it newest first, then runs the
//    shared divider once for the rate and once for the remaining minutes, each
//    only when its inputs allow a valid result.
//  - One reading at a time: the next beat can be taken in the cycle after the
//    result is loaded.
//  - s_tready is high only while the sequencer is idle. A finished result sits
//    in the output register; the next reading is taken while it waits, and
//    the sequencer holds its own result until the register frees.
//  - Reset: all slot windows are empty, logging on, retention 30 days. No
//    memory clearing pass is needed; entries above a slot's count are unread.
module battery_drain_runtime_estimator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// slot[2:0] now[42:3] stamp[82:43] percent_raw[90:83] charge[92:91] battery[93]
	input  logic [bdre_pkg::IN_W-1:0]           s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// recorded[0] rate_valid[1] rate_q8[18:2] remaining_valid[19] remaining_minutes[32:20]
	output logic [bdre_pkg::OUT_W-1:0]          m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bdre_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bdre_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bdre_pkg::*;

	bdre_state_t state_q, state_d;
	bdre_ctl_t   ctl;

	logic                  log_q;
	logic [DAYS_W-1:0]     days_q;

	logic [CNT_W-1:0]      cnt_q [SLOTS];
	logic [PCT_W-1:0]      lpct_q [SLOTS];
	logic [CHG_W-1:0]      lchg_q [SLOTS];
	logic                  lvld_q [SLOTS];

	edge_t                 mem [DEPTH];
	edge_t                 rd_data_s1;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic [ADDR_W-1:0]     raddr, waddr;

	edge_t                 buf_q [WINDOW];
	edge_t                 nbuf [WINDOW];

	logic [SLOT_W-1:0]     slot_q;
	logic [TIME_BITS-1:0]  now_q, stamp_q, ret_q, cutoff_q;
	logic [PCT_W-1:0]      pct_q;
	logic [CHG_W-1:0]      chg_q;
	logic                  batt_q, try_q, rec_q, all_in_q;
	logic [CNT_W-1:0]      ncur_q, ld_q, wb_q, wi_q, taken_q;
	logic                  stop_q;
	logic [TIME_BITS-1:0]  newt_q, oldt_q, span_q;
	logic [PCT_W-1:0]      newp_q, oldp_q, drop_q;
	logic                  rv_q, mv_q;
	logic [RATE_W-1:0]     rate_q;
	logic [MINS_W-1:0]     mins_q;
	logic [DIV_NUM_W-1:0]  num_q;
	logic [TIME_BITS-1:0]  den_q;
	logic                  div_done;
	logic [DIV_NUM_W-1:0]  div_quo;

	logic                  m_tvalid_q;
	logic [OUT_W-1:0]      m_tdata_q;

	// input fields
	logic [SLOT_W-1:0]     in_slot;
	logic [TIME_BITS-1:0]  in_now, in_stamp;
	logic [RAW_W-1:0]      in_raw;
	logic [PCT_W-1:0]      in_pct;
	logic [CHG_W-1:0]      in_chg;
	logic                  in_batt, in_try, s_acc;
	logic [DAYS_W-1:0]     days_eff;

	// insert / walk helpers
	logic [CNT_W-1:0]      pos, ncnt;
	logic                  full, ins_ok;
	edge_t                 ne, we;
	logic                  walk_ok;
	logic [TIME_BITS-1:0]  span_c;
	logic                  rv_c, mok_c;
	logic [PCT_W-1:0]      drop_c;

	assign in_slot  = s_tdata[2:0];
	assign in_now   = s_tdata[42:3];
	assign in_stamp = s_tdata[82:43];
	assign in_raw   = s_tdata[90:83];
	assign in_chg   = s_tdata[92:91];
	assign in_batt  = s_tdata[93];
	assign in_pct   = (in_raw > RAW_W'(FULL_LEVEL)) ? PCT_W'(FULL_LEVEL) : in_raw[PCT_W-1:0];
	assign in_try   = log_q && in_batt && !(lvld_q[in_slot] && lpct_q[in_slot] == in_pct
	                  && lchg_q[in_slot] == in_chg);
	assign s_acc    = s_tvalid && ctl.s_ready;
	assign days_eff = (days_q == '0) ? DAYS_W'(1) : days_q;

	assign s_tready  = ctl.s_ready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_q  <= 1'b1;
			days_q <= DAYS_W'(30);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOGGING:   log_q  <= cfg_data[0];
				REG_RETENTION: days_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_acc) state_d = ST_LOAD;
			ST_LOAD:   if (ld_q == ncur_q) state_d = ST_LDRAIN;
			ST_LDRAIN: state_d = ST_INS;
			ST_INS:    state_d = ins_ok ? ST_WB : ST_WALK;
			ST_WB:     if (wb_q + 1'b1 == ncur_q) state_d = ST_WALK;
			ST_WALK:   if (wi_q == '0 || stop_q) state_d = ST_CALC;
			ST_CALC:   state_d = rv_c ? ST_RSTART : ST_DONE;
			ST_RSTART: state_d = ST_RWAIT;
			ST_RWAIT:  if (div_done) state_d = ST_PREPM;
			ST_PREPM:  state_d = mok_c ? ST_MSTART : ST_DONE;
			ST_MSTART: state_d = ST_MWAIT;
			ST_MWAIT:  if (div_done) state_d = ST_DONE;
			ST_DONE:   if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control strobes
	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE:   ctl.s_ready = 1'b1;
			ST_LOAD:   ctl.rd_en = (ld_q != ncur_q);
			ST_WB:     ctl.wr_en = 1'b1;
			ST_RSTART,
			ST_MSTART: ctl.div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// edge memory, one read and one write port
	assign raddr = ADDR_W'(slot_q * WINDOW + ld_q[IDX_W-1:0]);
	assign waddr = ADDR_W'(slot_q * WINDOW + wb_q[IDX_W-1:0]);
	assign we    = buf_q[wb_q[IDX_W-1:0]];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) mem[waddr] <= we;
		if (ctl.rd_en) rd_data_s1 <= mem[raddr];
		rd_idx_s1 <= ld_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_vld_s1 <= 1'b0;
		else         rd_vld_s1 <= ctl.rd_en;
	end

	// insertion point and shifted window
	assign ne   = '{stamp: stamp_q, pct: pct_q, chg: chg_q};
	assign full = (ncur_q == CNT_W'(WINDOW));
	always_comb begin
		pos = '0;
		for (int j = 0; j < WINDOW; j++) begin
			if (CNT_W'(j) < ncur_q && buf_q[j].stamp <= stamp_q) pos = pos + 1'b1;
		end
		for (int j = 0; j < WINDOW; j++) begin
			if (full) begin
				if (CNT_W'(j + 1) < pos)       nbuf[j] = buf_q[(j + 1 < WINDOW) ? j + 1 : j];
				else if (CNT_W'(j + 1) == pos) nbuf[j] = ne;
				else                           nbuf[j] = buf_q[j];
			end else begin
				if (CNT_W'(j) < pos)       nbuf[j] = buf_q[j];
				else if (CNT_W'(j) == pos) nbuf[j] = ne;
				else                       nbuf[j] = buf_q[(j == 0) ? 0 : j - 1];
			end
		end
	end
	assign ins_ok = try_q && !(full && pos == '0);
	assign ncnt   = full ? ncur_q : ncur_q + 1'b1;

	// run walk, newest first
	always_comb begin
		edge_t e;
		e = buf_q[IDX_W'(wi_q - 1'b1)];
		walk_ok = (all_in_q || e.stamp >= cutoff_q) && e.chg == CHG_DISCHARGING
		          && (taken_q == '0 || e.pct >= oldp_q);
	end

	assign span_c = newt_q - oldt_q;
	assign drop_c = oldp_q - newp_q;
	assign rv_c   = taken_q >= CNT_W'(2) && oldp_q > newp_q
	                && span_c >= TIME_BITS'(MIN_SPAN_S);
	assign mok_c  = batt_q && chg_q == CHG_DISCHARGING && pct_q != '0
	                && span_q < TIME_BITS'(REM_SPAN_LIMIT);

	// per-slot metadata
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				cnt_q[i]  <= '0;
				lpct_q[i] <= '0;
				lchg_q[i] <= '0;
				lvld_q[i] <= 1'b0;
			end
		end else begin
			if (s_acc && in_try) begin
				lvld_q[in_slot] <= 1'b1;
				lpct_q[in_slot] <= in_pct;
				lchg_q[in_slot] <= in_chg;
			end
			if (state_q == ST_INS && ins_ok) cnt_q[slot_q] <= ncnt;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (rd_vld_s1) buf_q[rd_idx_s1] <= rd_data_s1;
		unique case (state_q)
			ST_IDLE: if (s_acc) begin
				slot_q  <= in_slot;
				now_q   <= in_now;
				stamp_q <= (in_stamp == '0) ? in_now : in_stamp;
				pct_q   <= in_pct;
				chg_q   <= in_chg;
				batt_q  <= in_batt;
				try_q   <= in_try;
				ret_q   <= TIME_BITS'(days_eff * DAY_S);
				ncur_q  <= cnt_q[in_slot];
				ld_q    <= '0;
			end
			ST_LOAD: if (ctl.rd_en) ld_q <= ld_q + 1'b1;
			ST_INS: begin
				all_in_q <= now_q <= ret_q;
				cutoff_q <= now_q - ret_q;
				rec_q    <= ins_ok;
				wb_q     <= '0;
				taken_q  <= '0;
				stop_q   <= 1'b0;
				if (ins_ok) begin
					for (int j = 0; j < WINDOW; j++) buf_q[j] <= nbuf[j];
					ncur_q <= ncnt;
					wi_q   <= ncnt;
				end else begin
					wi_q <= ncur_q;
				end
			end
			ST_WB: wb_q <= wb_q + 1'b1;
			ST_WALK: if (wi_q != '0 && !stop_q) begin
				if (walk_ok) begin
					if (taken_q == '0) begin
						newt_q <= buf_q[IDX_W'(wi_q - 1'b1)].stamp;
						newp_q <= buf_q[IDX_W'(wi_q - 1'b1)].pct;
					end
					oldt_q  <= buf_q[IDX_W'(wi_q - 1'b1)].stamp;
					oldp_q  <= buf_q[IDX_W'(wi_q - 1'b1)].pct;
					taken_q <= taken_q + 1'b1;
					wi_q    <= wi_q - 1'b1;
				end else begin
					stop_q <= 1'b1;
				end
			end
			ST_CALC: begin
				rv_q   <= rv_c;
				mv_q   <= 1'b0;
				rate_q <= '0;
				mins_q <= '0;
				span_q <= span_c;
				drop_q <= drop_c;
				num_q  <= DIV_NUM_W'(drop_c * RATE_SCALE);
				den_q  <= span_c;
			end
			ST_RWAIT: if (div_done) rate_q <= div_quo[RATE_W-1:0];
			ST_PREPM: begin
				num_q <= DIV_NUM_W'(pct_q) * DIV_NUM_W'(span_q[REM_SPAN_W-1:0]);
				den_q <= TIME_BITS'(drop_q * MIN_PER_DROP);
			end
			ST_MWAIT: if (div_done) begin
				if (div_quo >= DIV_NUM_W'(1) && div_quo <= DIV_NUM_W'(MAX_MINUTES)) begin
					mv_q   <= 1'b1;
					mins_q <= div_quo[MINS_W-1:0];
				end
			end
			default: ;
		endcase
	end

	bdre_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready))
			m_tdata_q <= {7'd0, mins_q, mv_q, rate_q, rv_q, rec_q};
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> cnt_q[slot_q] <= CNT_W'(WINDOW))
		else $error("slot edge count above window");
	a_wb_after_insert: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> rec_q && ncur_q != '0) else $error("write-back without an insert");
	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tdata_q[1] |-> m_tdata_q[18:2] <= RATE_W'(76800))
		else $error("rate out of range");
	a_mins_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tdata_q[19] |-> m_tdata_q[1] && m_tdata_q[32:20] != '0
		&& m_tdata_q[32:20] <= MINS_W'(MAX_MINUTES)) else $error("remaining out of range");

endmodule
